[rtl/cfp_pkg.sv]
// cfp_pkg: shared types and constants for the CRC-checked frame parser.
// Holds the parse phase enum, CRC-16 constants, configuration register indexes, status codes and beat widths.
// No dependencies.
`timescale 1ns / 1ps

package cfp_pkg;

    // CRC-16 (init 0xFFFF, poly 0x1021, MSB first, no reflection, no final xor)
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_WORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_WORD   = 2'd1;

    // Frame status codes
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_GOOD = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // Packed beat widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 9;

    typedef enum logic [3:0] {
        PH_START1 = 4'd0,
        PH_START2 = 4'd1,
        PH_KIND   = 4'd2,
        PH_LEN1   = 4'd3,
        PH_LEN2   = 4'd4,
        PH_DATA   = 4'd5,
        PH_CRC1   = 4'd6,
        PH_CRC2   = 4'd7,
        PH_END1   = 4'd8,
        PH_END2   = 4'd9
    } phase_t;

endpackage

[rtl/crc_checked_frame_parser.sv]
// crc_checked_frame_parser: byte-serial deframer with CRC-16 frame check.
// A beat accepted on s_ passes through the input register and the result register before it appears on m_.
// Throughput: one byte per cycle while m_tready does not stall the result register; the phase and CRC
// registers close a loop through the bytewise CRC update.
// Reset: aresetn (synchronous, active low) clears the pipeline, returns the parser to
// hunting for the start word and sets both pattern registers to zero.
// Depends on cfp_pkg and cfp_crc16_byte.
`timescale 1ns / 1ps

module crc_checked_frame_parser
    import cfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] in_byte
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                            // [39:24] frame_length, [41:40] frame_status,
                                            // [47:42] zero
    output logic [M_TUSER_W-1:0] m_tuser    // [0] payload_valid, [8:1] frame_kind
);

    // Configuration registers
    logic [15:0] start_word_reg;
    logic [15:0] end_word_reg;

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  kind_reg, kind_next;
    logic        hunt;

    // Result stage
    logic        out_valid_reg;
    logic        pv_reg, pv_next;
    logic [7:0]  pb_reg, pb_next;
    logic [15:0] pi_reg, pi_next;
    logic [7:0]  okind_reg;
    logic [15:0] olen_reg;
    logic [1:0]  status_reg, status_next;

    logic        advance;
    logic        fire;
    logic [15:0] crc_base;
    logic [15:0] crc_fed;
    logic [15:0] count_inc;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;

    // Write pattern registers; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_word_reg <= '0;
            end_word_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_WORD: start_word_reg <= cfg_data;
                REG_END_WORD:   end_word_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the incoming beat until the parser stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
        end
    end

    // CRC update: the first start byte restarts from the initial value
    assign crc_base  = (phase_reg == PH_START1) ? CRC_INIT : crc_reg;
    assign count_inc = count_reg + 16'd1;

    cfp_crc16_byte u_crc (
        .crc_in  (crc_base),
        .data_in (in_byte_reg),
        .crc_out (crc_fed)
    );

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        hunt       = 1'b0;
        unique case (phase_reg)
            PH_START1: begin
                if (in_byte_reg == start_word_reg[7:0]) phase_next = PH_START2;
            end
            PH_START2: begin
                if (in_byte_reg == start_word_reg[15:8]) begin
                    phase_next = PH_KIND;
                end else begin
                    hunt = 1'b1;
                end
            end
            PH_KIND:   phase_next = PH_LEN1;
            PH_LEN1:   phase_next = PH_LEN2;
            PH_LEN2: begin
                phase_next = ({in_byte_reg, length_reg[7:0]} == 16'd0) ? PH_CRC1 : PH_DATA;
            end
            PH_DATA: begin
                if (count_inc >= length_reg) phase_next = PH_CRC1;
            end
            PH_CRC1:   phase_next = PH_CRC2;
            PH_CRC2:   phase_next = PH_END1;
            PH_END1: begin
                if (in_byte_reg == end_word_reg[7:0]) begin
                    phase_next = PH_END2;
                end else begin
                    hunt = 1'b1;
                end
            end
            PH_END2:   hunt = 1'b1;
            default:   hunt = 1'b1;
        endcase
    end

    // Frame fields and result of this byte
    always_comb begin
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        length_next = length_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        pv_next     = 1'b0;
        pb_next     = 8'h00;
        pi_next     = 16'h0000;
        status_next = STATUS_NONE;
        unique case (phase_reg)
            PH_START1: begin
                if (in_byte_reg == start_word_reg[7:0]) crc_next = crc_fed;
            end
            PH_START2: begin
                if (in_byte_reg == start_word_reg[15:8]) crc_next = crc_fed;
            end
            PH_KIND: begin
                kind_next = in_byte_reg;
                crc_next  = crc_fed;
            end
            PH_LEN1: begin
                length_next = {8'h00, in_byte_reg};
                crc_next    = crc_fed;
            end
            PH_LEN2: begin
                length_next = {in_byte_reg, length_reg[7:0]};
                crc_next    = crc_fed;
                count_next  = 16'h0000;
            end
            PH_DATA: begin
                pv_next    = 1'b1;
                pb_next    = in_byte_reg;
                pi_next    = count_reg;
                crc_next   = crc_fed;
                count_next = count_inc;
            end
            PH_CRC1:   rx_crc_next = {8'h00, in_byte_reg};
            PH_CRC2:   rx_crc_next = {in_byte_reg, rx_crc_reg[7:0]};
            PH_END1: begin
                if (in_byte_reg != end_word_reg[7:0]) status_next = STATUS_BAD;
            end
            PH_END2: begin
                if (in_byte_reg == end_word_reg[15:8] && rx_crc_reg == crc_reg) begin
                    status_next = STATUS_GOOD;
                end else begin
                    status_next = STATUS_BAD;
                end
            end
            default: ;
        endcase
    end

    // Advance parser state; drop back to hunting with cleared fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START1;
            crc_reg    <= CRC_INIT;
            rx_crc_reg <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            kind_reg   <= '0;
        end else if (fire) begin
            if (hunt) begin
                phase_reg  <= PH_START1;
                crc_reg    <= CRC_INIT;
                rx_crc_reg <= '0;
                length_reg <= '0;
                count_reg  <= '0;
                kind_reg   <= '0;
            end else begin
                phase_reg  <= phase_next;
                crc_reg    <= crc_next;
                rx_crc_reg <= rx_crc_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                kind_reg   <= kind_next;
            end
        end
    end

    // Result register: valid under reset, payload only loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pv_reg     <= pv_next;
            pb_reg     <= pb_next;
            pi_reg     <= pi_next;
            okind_reg  <= kind_next;
            olen_reg   <= length_next;
            status_reg <= status_next;
        end
    end

    // Pack the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, status_reg, olen_reg, pi_reg, pb_reg};
    assign m_tuser  = {okind_reg, pv_reg};

endmodule

[rtl/cfp_crc16_byte.sv]
// cfp_crc16_byte: one-byte update of the CRC-16, MSB first.
// Purely combinational; depends on cfp_pkg for the polynomial.
`timescale 1ns / 1ps

module cfp_crc16_byte
    import cfp_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Fold the byte into the top and shift through eight polynomial steps
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule
